// ----- sv/dcd_pkg.sv -----
// Package for the day count to calendar date converter.
// Holds the calendar constants, the year counter control struct and small table functions.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package dcd_pkg;

    localparam int EPOCH_YEAR    = 1970;
    localparam int LEN_BITS      = 9;
    localparam int WD_EPOCH      = 3;

    localparam logic [LEN_BITS-1:0] YEAR_LEN      = 9'd365;
    localparam logic [LEN_BITS-1:0] LEAP_YEAR_LEN = 9'd366;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [1:0] EPOCH_MOD4   = 2'd2;
    localparam logic [6:0] EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] EPOCH_MOD400 = 9'd370;
    localparam logic [6:0] MOD100_LAST  = 7'd99;
    localparam logic [8:0] MOD400_LAST  = 9'd399;

    typedef struct packed {
        logic load;
        logic step;
    } t_year_ctl;

    function automatic logic [LEN_BITS-1:0] month_len(input logic [3:0] month,
                                                      input logic leap);
        logic [LEN_BITS-1:0] len;
        begin
            case (month)
                MONTH_FEB: len = leap ? 9'd29 : 9'd28;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 9'd30;
                default: len = 9'd31;
            endcase
            return len;
        end
    endfunction

    // Adds a small step to a weekday offset kept in the range 0 to 6.
    function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [1:0] inc);
        logic [3:0] sum;
        begin
            sum = {1'b0, wd} + {2'b00, inc};
            if (sum >= 4'd7) begin
                sum = sum - 4'd7;
            end
            return sum[2:0];
        end
    endfunction

    function automatic logic [2:0] mod7(input logic [5:0] val);
        logic [5:0] v;
        begin
            v = val;
            for (int i = 0; i < 5; i++) begin
                if (v >= 6'd7) begin
                    v = v - 6'd7;
                end
            end
            return v[2:0];
        end
    endfunction

endpackage

// ----- sv/dcd_sub_unit.sv -----
// Shared compare and subtract unit of the day count converter.
// Checks whether the remaining day count fits in a year or month and gives the difference.
// Depends on dcd_pkg.
`timescale 1ns / 1ps

module dcd_sub_unit #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0]             i_minuend,
    input  logic [dcd_pkg::LEN_BITS-1:0] i_len,
    output logic                         o_fits,
    output logic [WIDTH-1:0]             o_diff
);
    import dcd_pkg::*;

    logic [WIDTH-1:0] len_ext;

    assign len_ext = WIDTH'(i_len);
    assign o_fits  = (i_minuend <= len_ext);
    assign o_diff  = i_minuend - len_ext;

endmodule

// ----- sv/dcd_year_ctr.sv -----
// Year counter of the day count converter.
// Counts years from the epoch and keeps the year modulo 4, 100 and 400 for the leap rule.
// Depends on dcd_pkg.
`timescale 1ns / 1ps

module dcd_year_ctr #(
    parameter int YEAR_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dcd_pkg::t_year_ctl  i_ctl,
    output logic [YEAR_BITS-1:0] o_year,
    output logic                o_leap
);
    import dcd_pkg::*;

    logic [YEAR_BITS-1:0] r_year;
    logic [1:0]           r_mod4;
    logic [6:0]           r_mod100;
    logic [8:0]           r_mod400;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= YEAR_BITS'(EPOCH_YEAR);
            r_mod4   <= EPOCH_MOD4;
            r_mod100 <= EPOCH_MOD100;
            r_mod400 <= EPOCH_MOD400;
        end else if (i_ctl.load) begin
            r_year   <= YEAR_BITS'(EPOCH_YEAR);
            r_mod4   <= EPOCH_MOD4;
            r_mod100 <= EPOCH_MOD100;
            r_mod400 <= EPOCH_MOD400;
        end else if (i_ctl.step) begin
            r_year   <= r_year + 1'b1;
            r_mod4   <= r_mod4 + 1'b1;
            r_mod100 <= (r_mod100 == MOD100_LAST) ? 7'd0 : r_mod100 + 1'b1;
            r_mod400 <= (r_mod400 == MOD400_LAST) ? 9'd0 : r_mod400 + 1'b1;
        end
    end

    assign o_year = r_year;
    assign o_leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);

endmodule

// ----- sv/day_count_to_calendar_date.sv -----
// Day count to calendar date converter, top level with the sequencer.
// Depends on dcd_pkg, dcd_sub_unit and dcd_year_ctr.
//
// A day count (1 is 1970-01-01, 0 is read as 1) becomes the Gregorian year, month, day of
// month, weekday (1 Monday to 7 Sunday) and leap flag. One compare and subtract unit takes
// whole years off the count, one year per cycle, then whole months, one month per cycle,
// and a last state forms the weekday. That state waits as long as the previous result is
// still held in the output register and not taken. The input is not ready while a
// conversion runs; one finished result waits in the output register, so the next beat is
// taken while it is still pending.
`timescale 1ns / 1ps

module day_count_to_calendar_date #(
    parameter int DAY_COUNT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [DAY_COUNT_BITS-1:0] i_day_count,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [11:0]               o_year,
    output logic [3:0]                o_month,
    output logic [4:0]                o_day_of_month,
    output logic [2:0]                o_weekday,
    output logic                      o_leap
);
    import dcd_pkg::*;

    localparam int YEAR_BITS = $clog2(EPOCH_YEAR + (2 ** DAY_COUNT_BITS) / 365 + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_WDAY
    } t_state;

    t_state                  r_state, n_state;
    logic [DAY_COUNT_BITS-1:0] r_rem, n_rem;
    logic [3:0]              r_month, n_month;
    logic [2:0]              r_wd, n_wd;
    logic                    r_out_valid, n_out_valid;
    logic [11:0]             r_year_out, n_year_out;
    logic [3:0]              r_month_out, n_month_out;
    logic [4:0]              r_day_out, n_day_out;
    logic [2:0]              r_wday_out, n_wday_out;
    logic                    r_leap_out, n_leap_out;

    t_year_ctl               year_ctl;
    logic [YEAR_BITS-1:0]    year;
    logic                    leap;
    logic [LEN_BITS-1:0]     cur_len;
    logic                    fits;
    logic [DAY_COUNT_BITS-1:0] diff;
    logic                    in_beat;
    logic [LEN_BITS-1:0]     mon_len;

    assign in_beat = i_valid && o_ready;
    assign mon_len = month_len(r_month, leap);

    always_comb begin
        case (r_state)
            S_MONTH: cur_len = mon_len;
            default: cur_len = leap ? LEAP_YEAR_LEN : YEAR_LEN;
        endcase
    end

    dcd_sub_unit #(
        .WIDTH(DAY_COUNT_BITS)
    ) u_sub (
        .i_minuend(r_rem),
        .i_len    (cur_len),
        .o_fits   (fits),
        .o_diff   (diff)
    );

    dcd_year_ctr #(
        .YEAR_BITS(YEAR_BITS)
    ) u_year (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (year_ctl),
        .o_year (year),
        .o_leap (leap)
    );

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_month     = r_month;
        n_wd        = r_wd;
        n_out_valid = r_out_valid && !i_ready;
        n_year_out  = r_year_out;
        n_month_out = r_month_out;
        n_day_out   = r_day_out;
        n_wday_out  = r_wday_out;
        n_leap_out  = r_leap_out;
        year_ctl    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_rem         = (i_day_count == '0) ? DAY_COUNT_BITS'(1) : i_day_count;
                    n_month       = MONTH_JAN;
                    n_wd          = 3'(WD_EPOCH);
                    year_ctl.load = 1'b1;
                    n_state       = S_YEAR;
                end
            end
            S_YEAR: begin
                if (fits) begin
                    n_state = S_MONTH;
                end else begin
                    n_rem         = diff;
                    n_wd          = wd_add(r_wd, leap ? 2'd2 : 2'd1);
                    year_ctl.step = 1'b1;
                end
            end
            S_MONTH: begin
                if (fits || r_month == MONTH_DEC) begin
                    n_state = S_WDAY;
                end else begin
                    n_rem   = diff;
                    n_month = r_month + 1'b1;
                    n_wd    = wd_add(r_wd, 2'(mon_len - 9'd28));
                end
            end
            S_WDAY: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_year_out  = 12'(year);
                    n_month_out = r_month;
                    n_day_out   = r_rem[4:0];
                    n_wday_out  = mod7({3'b000, r_wd} + {1'b0, r_rem[4:0]} - 6'd1) + 3'd1;
                    n_leap_out  = leap;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_rem       <= n_rem;
        r_month     <= n_month;
        r_wd        <= n_wd;
        r_year_out  <= n_year_out;
        r_month_out <= n_month_out;
        r_day_out   <= n_day_out;
        r_wday_out  <= n_wday_out;
        r_leap_out  <= n_leap_out;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_year         = r_year_out;
    assign o_month        = r_month_out;
    assign o_day_of_month = r_day_out;
    assign o_weekday      = r_wday_out;
    assign o_leap         = r_leap_out;

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_ready)
        else $error("input still ready after a beat was taken");

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR || r_state == S_MONTH || r_state == S_WDAY) |-> (r_rem != '0))
        else $error("remaining day count reached zero during a conversion");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH || r_state == S_WDAY)
            |-> (r_month >= MONTH_JAN && r_month <= MONTH_DEC))
        else $error("month counter left its range");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_day_of_month != 5'd0 && o_weekday != 3'd0 && o_month != 4'd0))
        else $error("result field out of range");

endmodule

// ----- tb/sv/date_checker.sv -----
// Checker for the day count to calendar date converter: watches both channels,
// predicts each date on its own and compares every result beat with it.
// Depends on dcd_pkg for the epoch year and the month names.
`timescale 1ns / 1ps

module date_checker
    import dcd_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [COUNT_BITS-1:0] i_day_count,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [11:0]           i_year,
    input  logic [3:0]            i_month,
    input  logic [4:0]            i_day_of_month,
    input  logic [2:0]            i_weekday,
    input  logic                  i_leap,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
        logic        leap;
    } t_cal_date;

    t_cal_date dates_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit is_leap_year(input int unsigned yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mon, input bit lp);
        case (mon)
            MONTH_FEB: return lp ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic t_cal_date calendar_of(input logic [COUNT_BITS-1:0] count);
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        int unsigned span;
        int unsigned zy;
        int unsigned zm;
        int unsigned k;
        int unsigned j;
        int unsigned h;
        bit          lp;
        t_cal_date   d;
        days = (count == 0) ? 1 : count;
        yr   = EPOCH_YEAR;
        span = is_leap_year(yr) ? 366 : 365;
        while (days > span) begin
            days = days - span;
            yr   = yr + 1;
            span = is_leap_year(yr) ? 366 : 365;
        end
        lp  = is_leap_year(yr);
        mon = 1;
        while (mon < 12 && days > days_in_month(mon, lp)) begin
            days = days - days_in_month(mon, lp);
            mon  = mon + 1;
        end
        zy = yr;
        zm = mon;
        if (zm < 3) begin
            zm = zm + 12;
            zy = zy - 1;
        end
        k = zy % 100;
        j = zy / 100;
        h = (days + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        d.year         = 12'(yr);
        d.month        = 4'(mon);
        d.day_of_month = 5'(days);
        d.weekday      = 3'((h + 5) % 7 + 1);
        d.leap         = lp;
        return d;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got, inout int errs);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cal_date want;
        int        errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (dates_due.size() == 0) begin
                    $error("result beat with no date pending: year %0d month %0d day %0d",
                           i_year, i_month, i_day_of_month);
                    errs++;
                end else begin
                    want = dates_due.pop_front();
                    check_field("year", want.year, i_year, errs);
                    check_field("month", want.month, i_month, errs);
                    check_field("day_of_month", want.day_of_month, i_day_of_month, errs);
                    check_field("weekday", want.weekday, i_weekday, errs);
                    check_field("leap", want.leap, i_leap, errs);
                end
            end
            if (i_in_valid && i_in_ready) begin
                dates_due.push_back(calendar_of(i_day_count));
            end
        end
        o_fail_count <= o_fail_count + errs;
        o_pending    <= dates_due.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the testbench for the day count to calendar date converter.
// Drives day counts and the result ready with random idling, and gives the verdict.
// Depends on day_count_to_calendar_date and date_checker.
`timescale 1ns / 1ps

module tb;

    localparam int COUNT_BITS   = 16;
    localparam int RANDOM_BEATS = 500;
    localparam int CALM_BEATS   = 60;
    localparam int HOLD_AT      = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 250;
    localparam int LIMIT        = 600_000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [COUNT_BITS-1:0] i_day_count;
    logic                  o_valid;
    logic                  i_ready;
    logic [11:0]           o_year;
    logic [3:0]            o_month;
    logic [4:0]            o_day_of_month;
    logic [2:0]            o_weekday;
    logic                  o_leap;

    int fails;
    int pending;
    int sent   = 0;
    int cycles = 0;
    bit calm   = 1'b0;

    logic [COUNT_BITS-1:0] directed_counts [25] = '{
        16'd0, 16'd1, 16'd2, 16'd31, 16'd32, 16'd59, 16'd60, 16'd365, 16'd366,
        16'd730, 16'd731, 16'd790, 16'd791, 16'd1096, 16'd1097, 16'd11017,
        16'd47541, 16'd47542, 16'd65534, 16'd65535, 16'h5555, 16'hAAAA,
        16'h8000, 16'h7FFF, 16'd10957
    };

    day_count_to_calendar_date #(
        .DAY_COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_day_count    (i_day_count),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_weekday      (o_weekday),
        .o_leap         (o_leap)
    );

    date_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_day_count    (i_day_count),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_year         (o_year),
        .i_month        (o_month),
        .i_day_of_month (o_day_of_month),
        .i_weekday      (o_weekday),
        .i_leap         (o_leap),
        .o_fail_count   (fails),
        .o_pending      (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(input logic [COUNT_BITS-1:0] count);
        i_valid     <= 1'b1;
        i_day_count <= count;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        sent++;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid     <= 1'b0;
            i_day_count <= COUNT_BITS'($urandom);
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
    endtask

    initial begin : receiver
        int stall_left;
        bit held;
        i_ready    = 1'b0;
        stall_left = 0;
        held       = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && sent >= HOLD_AT) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready    <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [COUNT_BITS-1:0] pick;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_day_count = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_counts[n]) begin
            send_beat(directed_counts[n]);
        end
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n >= RANDOM_BEATS - CALM_BEATS) begin
                calm = 1'b1;
            end
            case ($urandom_range(0, 3))
                0, 1: pick = COUNT_BITS'($urandom);
                2: pick = COUNT_BITS'($urandom_range(0, 2000));
                default: pick = COUNT_BITS'($urandom_range(60000, 65535));
            endcase
            send_beat(pick);
        end
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
